@@ hdl/atilt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt angle package
// Shared constants, the arctangent step table and the lane record that
// travels through the chain of CORDIC cells.
// ----------------------------------------------------------------------------
package atilt_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 12;
    localparam int STEP_TABLE_LEN   = 24;
    localparam int ANGLE_W_MAX      = 16;
    localparam int TILT_W           = 12;
    localparam int SAMPLE_W         = 16;
    localparam int ACC_W            = 32;
    localparam int CW               = 28;

    localparam logic [ACC_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ACC_W-1:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic [ACC_W-1:0] STEP_ANGLE [STEP_TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                   upd;
        logic                   freeze;
        logic [SAMPLE_W-1:0]    x_raw;
        logic [SAMPLE_W-1:0]    y_raw;
        logic [SAMPLE_W-1:0]    z_raw;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic [ACC_W-1:0]       acc;
    } lane_t;

endpackage
`default_nettype wire

@@ hdl/accel_tilt_angle_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Accelerometer tilt angle
// Turns one X/Y/Z burst per beat into a held tilt angle and held samples.
// ----------------------------------------------------------------------------
// Each slave beat carries the six sample bytes in s_tdata and the read
// completion flag in s_tuser. Each beat produces exactly one master beat with
// the held angle and the held X, Y and Z samples, in the order accepted.
// The cfg channel writes the sensor-present bit and is always ready; the user
// must see that it is written only while the block is idle, which the block does not enforce.
// The angle comes from a row of CORDIC_STEPS registered vectoring cells,
// one step per cell, followed by the output register that also holds the
// stored values. One beat is accepted every cycle while s_tready is high.
// A beat passes through every cell and then the output register to m_tdata.
// The whole row advances together; when the receiver stalls with a result
// waiting, s_tready falls and every cell holds its beat until m_tready.
// Reset clears the sensor-present bit, the held values and every valid flag.
// ----------------------------------------------------------------------------
module accel_tilt_angle_top #(
    parameter int CORDIC_STEPS = atilt_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = atilt_pkg::ANGLE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
    input  wire logic [47:0] s_tdata,
    // read_ok
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tilt_angle, x_value, y_value, z_value, four zero bits
    output logic [63:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    localparam int AngleExtW = atilt_pkg::ANGLE_W_MAX;

    logic                           sensor_present_reg;
    logic                           m_tvalid_reg;
    logic [atilt_pkg::SAMPLE_W-1:0] held_x_reg;
    logic [atilt_pkg::SAMPLE_W-1:0] held_y_reg;
    logic [atilt_pkg::SAMPLE_W-1:0] held_z_reg;
    logic [ANGLE_BITS-1:0]          held_angle_reg;
    logic [AngleExtW-1:0]           angle_ext;
    logic                           adv;
    logic                           valid_c [CORDIC_STEPS+1];
    atilt_pkg::lane_t               lane_c  [CORDIC_STEPS+1];

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign valid_c[0] = s_tvalid;

    atilt_prep u_prep (
        .beat_data (s_tdata),
        .read_ok   (s_tuser),
        .present   (sensor_present_reg),
        .lane_o    (lane_c[0])
    );

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        atilt_cell #(
            .STEP (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .valid_i (valid_c[k]),
            .lane_i  (lane_c[k]),
            .valid_o (valid_c[k+1]),
            .lane_o  (lane_c[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_present_reg <= 1'b0;
        end else if (cfg_valid) begin
            sensor_present_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_z_reg     <= '0;
            held_angle_reg <= '0;
        end else if (adv) begin
            m_tvalid_reg <= valid_c[CORDIC_STEPS];
            if (valid_c[CORDIC_STEPS] && lane_c[CORDIC_STEPS].upd) begin
                held_x_reg     <= lane_c[CORDIC_STEPS].x_raw;
                held_y_reg     <= lane_c[CORDIC_STEPS].y_raw;
                held_z_reg     <= lane_c[CORDIC_STEPS].z_raw;
                held_angle_reg <= lane_c[CORDIC_STEPS].acc[atilt_pkg::ACC_W-1 -: ANGLE_BITS];
            end
        end
    end

    assign angle_ext = AngleExtW'(held_angle_reg);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'b0000, held_z_reg, held_y_reg, held_x_reg,
                        angle_ext[atilt_pkg::TILT_W-1:0]};

`ifndef SYNTH
    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(adv && valid_c[CORDIC_STEPS]) |=>
            ($stable(held_x_reg) && $stable(held_y_reg) && $stable(held_z_reg)
             && $stable(held_angle_reg)))
        else $error("held values changed without a result leaving the cells");

    a_out_follows_row: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> (m_tvalid_reg == $past(valid_c[CORDIC_STEPS])))
        else $error("output valid does not follow the last cell");

    a_axis_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_c[CORDIC_STEPS] && lane_c[CORDIC_STEPS].freeze) |->
            (lane_c[CORDIC_STEPS].acc[29:0] == '0))
        else $error("axis case lost its exact quarter-turn angle");
`endif

endmodule
`default_nettype wire

@@ hdl/atilt_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt angle input preparation
// Assembles the samples, resolves the axis cases exactly and sets up the
// scaled, half-turn folded vector that enters the first cell.
// ----------------------------------------------------------------------------
module atilt_prep (
    input  wire logic [47:0]       beat_data,
    input  wire logic              read_ok,
    input  wire logic              present,
    output atilt_pkg::lane_t       lane_o
);

    logic [atilt_pkg::SAMPLE_W-1:0]  x_raw;
    logic [atilt_pkg::SAMPLE_W-1:0]  y_raw;
    logic signed [atilt_pkg::CW-1:0] sx;
    logic signed [atilt_pkg::CW-1:0] sy;

    assign x_raw = {beat_data[15:8], beat_data[7:0]};
    assign y_raw = {beat_data[31:24], beat_data[23:16]};
    assign sx    = {{4{x_raw[15]}}, x_raw, 8'h00};
    assign sy    = {{4{y_raw[15]}}, y_raw, 8'h00};

    always_comb begin
        lane_o.upd    = present & read_ok;
        lane_o.x_raw  = x_raw;
        lane_o.y_raw  = y_raw;
        lane_o.z_raw  = {beat_data[47:40], beat_data[39:32]};
        lane_o.freeze = 1'b0;
        lane_o.cx     = sx;
        lane_o.cy     = sy;
        lane_o.acc    = '0;
        if (y_raw == '0) begin
            lane_o.freeze = 1'b1;
            lane_o.acc    = x_raw[15] ? atilt_pkg::HALF_TURN : '0;
        end else if (x_raw == '0) begin
            lane_o.freeze = 1'b1;
            lane_o.acc    = y_raw[15] ? (atilt_pkg::HALF_TURN + atilt_pkg::QUARTER_TURN)
                                      : atilt_pkg::QUARTER_TURN;
        end else if (x_raw[15]) begin
            lane_o.cx  = -sx;
            lane_o.cy  = -sy;
            lane_o.acc = atilt_pkg::HALF_TURN;
        end
    end

endmodule
`default_nettype wire

@@ hdl/atilt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt angle CORDIC cell
// One registered vectoring step; the row of cells forms the angle pipeline.
// ----------------------------------------------------------------------------
module atilt_cell #(
    parameter int STEP = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              valid_i,
    input  wire atilt_pkg::lane_t  lane_i,
    output logic                   valid_o,
    output atilt_pkg::lane_t       lane_o
);

    logic                          valid_reg;
    atilt_pkg::lane_t              lane_reg;
    atilt_pkg::lane_t              lane_next;
    logic signed [atilt_pkg::CW-1:0] dx;
    logic signed [atilt_pkg::CW-1:0] dy;

    assign dx = lane_i.cy >>> STEP;
    assign dy = lane_i.cx >>> STEP;

    always_comb begin
        lane_next = lane_i;
        if (lane_i.upd && !lane_i.freeze) begin
            if (!lane_i.cy[atilt_pkg::CW-1]) begin
                lane_next.cx  = lane_i.cx + dx;
                lane_next.cy  = lane_i.cy - dy;
                lane_next.acc = lane_i.acc + atilt_pkg::STEP_ANGLE[STEP];
            end else begin
                lane_next.cx  = lane_i.cx - dx;
                lane_next.cy  = lane_i.cy + dy;
                lane_next.acc = lane_i.acc - atilt_pkg::STEP_ANGLE[STEP];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign valid_o = valid_reg;
    assign lane_o  = lane_reg;

endmodule
`default_nettype wire

@@ test/tilt_angle_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt angle checker
// Watches the burst, result and sensor-present channels of the tilt angle
// block. It keeps its own copy of the held samples and angle, works out the
// expected result of every accepted burst with a bit-exact CORDIC vectoring
// predictor, and compares each result beat field by field with the oldest
// expected result.
// ----------------------------------------------------------------------------
module tilt_angle_checker #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,
    output int               mismatches,
    output int               outstanding,
    output int               results_checked,
    output int               angle_updates
);

    // Members run from the highest bits down, so the angle comes last.
    typedef struct packed {
        logic [15:0] z_value;
        logic [15:0] y_value;
        logic [15:0] x_value;
        logic [11:0] angle;
    } tilt_result_t;

    localparam int          TURN_TABLE_LEN = 24;
    localparam logic [31:0] HALF_REV       = 32'h8000_0000;
    localparam logic [31:0] QUARTER_REV    = 32'h4000_0000;

    // Angle of atan(2^-i) with a full turn as 2^32.
    localparam logic [31:0] TURN_STEP [TURN_TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    tilt_result_t expected_results [$];
    logic         sensor_present;
    logic [15:0]  held_x;
    logic [15:0]  held_y;
    logic [15:0]  held_z;
    logic [11:0]  held_angle;

    function automatic logic [31:0] vector_phase(logic signed [15:0] sx,
                                                 logic signed [15:0] sy);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] acc;
        if (sy == 0)
            return (sx < 0) ? HALF_REV : 32'd0;
        if (sx == 0)
            return (sy > 0) ? QUARTER_REV : HALF_REV + QUARTER_REV;
        x   = longint'(sx) * 256;
        y   = longint'(sy) * 256;
        acc = 32'd0;
        // Vectors in the left half plane are turned by half a turn first.
        if (x < 0) begin
            x   = -x;
            y   = -y;
            acc = HALF_REV;
        end
        for (int i = 0; i < CORDIC_STEPS && i < TURN_TABLE_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x   = x + dx;
                y   = y - dy;
                acc = acc + TURN_STEP[i];
            end else begin
                x   = x - dx;
                y   = y + dy;
                acc = acc - TURN_STEP[i];
            end
        end
        return acc;
    endfunction

    function automatic void report_field(string field, logic [15:0] want,
                                         logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        tilt_result_t got;
        tilt_result_t want;
        logic [31:0]  phase;
        if (!aresetn) begin
            expected_results.delete();
            sensor_present = 1'b0;
            held_x         = 16'd0;
            held_y         = 16'd0;
            held_z         = 16'd0;
            held_angle     = 12'd0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                got = m_tdata[59:0];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result beat with nothing expected, got %h",
                             $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    report_field("tilt_angle", {4'd0, want.angle}, {4'd0, got.angle});
                    report_field("x_value", want.x_value, got.x_value);
                    report_field("y_value", want.y_value, got.y_value);
                    report_field("z_value", want.z_value, got.z_value);
                    report_field("padding", 16'd0, {12'd0, m_tdata[63:60]});
                end
            end
            if (cfg_valid && cfg_ready)
                sensor_present = cfg_data;
            if (s_tvalid && s_tready) begin
                if (sensor_present && s_tuser) begin
                    held_x     = s_tdata[15:0];
                    held_y     = s_tdata[31:16];
                    held_z     = s_tdata[47:32];
                    phase      = vector_phase(held_x, held_y);
                    phase      = (phase >> (32 - ANGLE_BITS)) & ((32'd1 << ANGLE_BITS) - 1);
                    held_angle = phase[11:0];
                    angle_updates++;
                end
                want.angle   = held_angle;
                want.x_value = held_x;
                want.y_value = held_y;
                want.z_value = held_z;
                expected_results.push_back(want);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt angle regression
// Drives accelerometer bursts into the tilt angle block: a directed set of
// axes, the origin, extreme samples and held bursts, then random bursts under
// three patterns of sender and receiver idling, with the sensor-present bit
// switched between phases. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CORDIC_STEPS = atilt_pkg::CORDIC_STEPS_DEF;
    localparam int ANGLE_BITS   = atilt_pkg::ANGLE_BITS_DEF;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [47:0] s_tdata   = 48'd0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [63:0] m_tdata;
    wire         cfg_ready;

    int mismatches;
    int outstanding;
    int results_checked;
    int angle_updates;
    int tx_idle      = 0;
    int rx_idle      = 0;
    int bursts_sent  = 0;
    int present_sets = 0;

    always #2 aclk = ~aclk;

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= rx_idle);

    accel_tilt_angle_top #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .ANGLE_BITS  (ANGLE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    tilt_angle_checker #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .ANGLE_BITS  (ANGLE_BITS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_checked(results_checked),
        .angle_updates  (angle_updates)
    );

    // Samples travel low byte first, X in the lowest bits.
    function automatic logic [47:0] burst(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [15:0] random_sample();
        case ($urandom_range(9))
            5: return 16'($signed($urandom_range(16)) - 8);
            6: return 16'd0;
            7: begin
                case ($urandom_range(3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            8, 9: return 16'($signed($urandom_range(2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_burst(logic [47:0] data, logic read_ok);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= read_ok;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bursts_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random_burst();
        logic [15:0] x;
        logic [15:0] y;
        x = random_sample();
        y = random_sample();
        case ($urandom_range(9))
            0: x = 16'd0;
            1: y = 16'd0;
            default: ;
        endcase
        send_burst(burst(x, y, 16'($urandom)), $urandom_range(99) < 85);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    task automatic write_present(logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        present_sets++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // With the sensor absent, completed reads must not change anything.
        send_burst(burst(16'h1234, 16'h5678, 16'h9ABC), 1'b1);
        send_burst(burst(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
        drain_results();
        write_present(1'b1);

        send_burst(burst(16'h0000, 16'h0000, 16'h0000), 1'b1);
        send_burst(burst(16'h0001, 16'h0000, 16'h7FFF), 1'b1);
        send_burst(burst(16'hFFFF, 16'h0000, 16'h8000), 1'b1);
        send_burst(burst(16'h0000, 16'h0001, 16'h0001), 1'b1);
        send_burst(burst(16'h0000, 16'hFFFF, 16'hFFFF), 1'b1);
        send_burst(burst(16'h7FFF, 16'h0000, 16'h0000), 1'b1);
        send_burst(burst(16'h8000, 16'h0000, 16'h0000), 1'b1);
        send_burst(burst(16'h0000, 16'h7FFF, 16'h0000), 1'b1);
        send_burst(burst(16'h0000, 16'h8000, 16'h0000), 1'b1);
        send_burst(burst(16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b1);
        send_burst(burst(16'h8000, 16'h8000, 16'h8000), 1'b1);
        send_burst(burst(16'h7FFF, 16'h8000, 16'h1234), 1'b1);
        send_burst(burst(16'h8000, 16'h7FFF, 16'h4321), 1'b1);
        send_burst(burst(16'hFFFF, 16'hFFFF, 16'h00FF), 1'b0);
        send_burst(burst(16'h0001, 16'h0001, 16'hFF00), 1'b1);
        send_burst(burst(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
        send_burst(burst(16'h0001, 16'hFFFF, 16'h0000), 1'b1);
        send_burst(burst(16'hFFFF, 16'h0001, 16'h0000), 1'b1);
        send_burst(burst(16'h5555, 16'hAAAA, 16'h5555), 1'b1);
        send_burst(burst(16'hAAAA, 16'h5555, 16'hAAAA), 1'b1);
        send_burst(burst(16'h0000, 16'h0000, 16'h0000), 1'b0);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle = 14;
                    rx_idle = 51;
                end
                1: begin
                    tx_idle = 51;
                    rx_idle = 14;
                end
                default: begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
            endcase
            for (int n = 0; n < 440; n++) begin
                if (n == 220)
                    drain_results();
                send_random_burst();
            end
            drain_results();
            write_present(1'b0);
            repeat (50) send_random_burst();
            drain_results();
            write_present(1'b1);
        end

        drain_results();
        repeat (CORDIC_STEPS + 8) @(negedge aclk);
        $display("Sent %0d bursts, checked %0d results, %0d of which took a new angle.",
                 bursts_sent, results_checked, angle_updates);
        $display("Sensor-present bit written %0d times across three idling patterns.",
                 present_sets);
        if (mismatches == 0 && outstanding == 0)
            $display("accel_tilt_angle_top regression: pass");
        else
            $display("accel_tilt_angle_top regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("accel_tilt_angle_top regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/atilt_pkg.sv
hdl/atilt_prep.sv
hdl/atilt_cell.sv
hdl/accel_tilt_angle_top.sv
test/tilt_angle_checker.sv
test/testbench.sv
